/* rtl/core/escd_pkg.sv */
// Shared types, character codes and digit helpers for the escape sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package escd_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_BSLASH,
		MODE_CARET,
		MODE_HEX1,
		MODE_HEX2,
		MODE_OCT1,
		MODE_OCT2
	} mode_t;

	// one decoded result item
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_t;

	// what the front hands to the queue for one accepted item
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_3       = 8'h33;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_S       = 8'h73;
	localparam logic [7:0] CH_E       = 8'h65;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_A_LC    = 8'h61;
	localparam logic [7:0] CH_Z_LC    = 8'h7A;
	localparam logic [7:0] CH_A_UC    = 8'h41;
	localparam logic [7:0] CH_Z_UC    = 8'h5A;

	localparam logic [7:0] ESC_SPACE  = 8'h20;
	localparam logic [7:0] ESC_ESC    = 8'd27;
	localparam logic [7:0] ESC_BS     = 8'd8;
	localparam logic [7:0] ESC_LF     = 8'd10;
	localparam logic [7:0] ESC_CR     = 8'd13;
	localparam logic [7:0] ESC_TAB    = 8'd9;

	localparam logic [7:0] CTRL_MASK  = 8'h1F;
	localparam logic [7:0] HEX_LC_OFS = 8'd87;  // 'a' - 10
	localparam logic [7:0] HEX_UC_OFS = 8'd55;  // 'A' - 10

	// any letter counts: 'z' gives 35
	function automatic logic [5:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_0 && c <= CH_9)
			d = c - CH_0;
		else if (c >= CH_A_LC && c <= CH_Z_LC)
			d = c - HEX_LC_OFS;
		else if (c >= CH_A_UC && c <= CH_Z_UC)
			d = c - HEX_UC_OFS;
		return d[5:0];
	endfunction

	// 8 and 9 are taken as they are
	function automatic logic [3:0] oct_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= CH_0 && c <= CH_9)
			d = c - CH_0;
		return d[3:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/escd_front.sv */
// Front end: parse state machine that classifies each byte and builds result items.
`timescale 1ns / 1ps
`default_nettype none

module escd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          room,
	output escd_pkg::push_t    push
);
	import escd_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] part_q, part_d;
	logic       acc;
	logic [1:0] n;
	res_t       r0, r1;
	logic [5:0] hv;
	logic [3:0] ov;

	assign in_ready = room;
	assign acc      = in_valid & room;
	assign hv       = hex_val(in_byte);
	assign ov       = oct_val(in_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			part_q <= 8'd0;
		end else if (acc) begin
			mode_q <= mode_d;
			part_q <= part_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		part_d = part_q;
		n      = 2'd0;
		r0     = '{data: in_byte, last: 1'b0};
		r1     = '{data: CH_NUL, last: 1'b1};
		if (in_byte == CH_NUL) begin
			// end of string: flush a pending numeric escape, then terminator
			mode_d = MODE_NORMAL;
			part_d = 8'd0;
			if (mode_q == MODE_HEX1 || mode_q == MODE_HEX2 ||
			    mode_q == MODE_OCT1 || mode_q == MODE_OCT2) begin
				r0 = '{data: part_q, last: 1'b0};
				n  = 2'd2;
			end else begin
				r0 = '{data: CH_NUL, last: 1'b1};
				n  = 2'd1;
			end
		end else begin
			unique case (mode_q)
				MODE_NORMAL: begin
					if (in_byte == CH_BSLASH)
						mode_d = MODE_BSLASH;
					else if (in_byte == CH_CARET)
						mode_d = MODE_CARET;
					else
						n = 2'd1;
				end
				MODE_BSLASH: begin
					mode_d = MODE_NORMAL;
					if (in_byte >= CH_0 && in_byte <= CH_3) begin
						part_d = {in_byte[1:0], 6'd0};
						mode_d = MODE_OCT1;
					end else begin
						unique case (in_byte)
							CH_X: begin
								part_d = 8'd0;
								mode_d = MODE_HEX1;
							end
							CH_BSLASH: n = 2'd1;
							CH_CARET:  n = 2'd1;
							CH_S: begin r0.data = ESC_SPACE; n = 2'd1; end
							CH_E: begin r0.data = ESC_ESC;   n = 2'd1; end
							CH_B: begin r0.data = ESC_BS;    n = 2'd1; end
							CH_N: begin r0.data = ESC_LF;    n = 2'd1; end
							CH_R: begin r0.data = ESC_CR;    n = 2'd1; end
							CH_T: begin r0.data = ESC_TAB;   n = 2'd1; end
							default: ;  // unknown escape, macro trigger included
						endcase
					end
				end
				MODE_CARET: begin
					r0.data = in_byte & CTRL_MASK;
					n       = 2'd1;
					mode_d  = MODE_NORMAL;
				end
				MODE_HEX1: begin
					part_d = {hv[3:0], 4'd0};
					mode_d = MODE_HEX2;
				end
				MODE_HEX2: begin
					r0.data = part_q + {2'd0, hv};
					n       = 2'd1;
					part_d  = 8'd0;
					mode_d  = MODE_NORMAL;
				end
				MODE_OCT1: begin
					part_d = part_q + {1'b0, ov, 3'd0};
					mode_d = MODE_OCT2;
				end
				MODE_OCT2: begin
					r0.data = part_q + {4'd0, ov};
					n       = 2'd1;
					part_d  = 8'd0;
					mode_d  = MODE_NORMAL;
				end
				default: begin
					mode_d = MODE_NORMAL;
					part_d = 8'd0;
					n      = 2'd1;
				end
			endcase
		end
		push.cnt = acc ? n : 2'd0;
		push.r0  = r0;
		push.r1  = r1;
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_byte == CH_NUL |=> mode_q == MODE_NORMAL && part_q == 8'd0)
		else $error("mode not cleared after terminator");

	a_push_max: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd3)
		else $error("front pushed more than two results");

	a_two_ends_in_term: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> push.r1.last && !push.r0.last)
		else $error("double push without terminator last");

endmodule

`default_nettype wire

/* rtl/core/escd_queue.sv */
// Result queue between front and back: two writes, one read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module escd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire escd_pkg::push_t push,
	output logic                 room,
	output logic                 not_empty,
	output escd_pkg::res_t       head,
	input  wire logic            pop
);
	import escd_pkg::*;

	res_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;
	logic [QAW-1:0]   wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + QAW'(1);
	assign room      = cnt_q <= QCW'(QDEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem_q[wr_ptr_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push.cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			cnt_q <= cnt_q + QCW'(push.cnt) - QCW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty result queue");

endmodule

`default_nettype wire

/* rtl/core/escd_back.sv */
// Back end: output register that drains the result queue onto the out channel.
`timescale 1ns / 1ps
`default_nettype none

module escd_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           not_empty,
	input  wire escd_pkg::res_t head,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                is_end
);
	import escd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign pop       = not_empty & (~valid_q | out_ready);
	assign out_valid = valid_q;
	assign out_byte  = res_q.data;
	assign is_end    = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (~valid_q | out_ready)
			valid_q <= not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= head;
	end

endmodule

`default_nettype wire

/* rtl/core/escd_back_sv_unused_placeholder.sv */
// Output-side check: every terminator item carries a zero byte.
`timescale 1ns / 1ps
`default_nettype none

module escd_term_chk (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       out_valid,
	input  wire logic [7:0] out_byte,
	input  wire logic       is_end
);
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> out_byte == 8'd0)
		else $error("terminator item with nonzero byte");
endmodule

`default_nettype wire

/* rtl/core/escape_sequence_decoder.sv */
// Escape sequence decoder top level: front parser, result queue, output register.
//
// Usage: source bytes enter on in_valid/in_ready/in_byte, one per cycle.
// Backslash and caret escapes are decoded; each byte gives zero, one or
// two result items on out_valid/out_ready/out_byte/is_end. A zero byte
// closes the string: a pending numeric escape is flushed first, then a
// terminator item with is_end set and out_byte zero. A new string may
// follow at once.
// Each result is written into the queue when its byte is accepted and
// then passes through the output register onto the out channel.
// Throughput: one byte per cycle while the output side keeps up; a zero
// byte that flushes a numeric escape makes two items, and the output
// register drains one item per cycle.
// in_ready is high while the four-entry result queue has room for two
// items, so a stalled receiver fills the queue and then holds off input.
// Reset (arst_n low) returns the parser to plain text and empties the
// queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            is_end
);
	import escd_pkg::*;

	push_t push;
	res_t  head;
	logic  room;
	logic  not_empty;
	logic  pop;

	escd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.room     (room),
		.push     (push)
	);

	escd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop)
	);

	escd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.is_end    (is_end)
	);

	escd_term_chk u_term_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.is_end    (is_end)
	);

endmodule

`default_nettype wire
